// ===== rtl/ttlc_pkg.sv =====
// Shared types, codes and the seven-segment table of the two-road traffic light controller.
package ttlc_pkg;

	// Mode codes carried in the op field
	localparam logic [1:0] OP_AUTO     = 2'd0;
	localparam logic [1:0] OP_MANUAL   = 2'd1;
	localparam logic [1:0] OP_MIDNIGHT = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_ROAD1_GREEN = 2'd0;
	localparam logic [1:0] CFG_ROAD2_GREEN = 2'd1;
	localparam logic [1:0] CFG_YELLOW      = 2'd2;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 6;
	localparam int unsigned GREEN_W     = 6;
	localparam int unsigned YELLOW_W    = 4;
	localparam int unsigned COUNT_W     = 7;

	localparam logic [GREEN_W-1:0]  GREEN_RESET  = 6'd20;
	localparam logic [YELLOW_W-1:0] YELLOW_RESET = 4'd3;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = 7'd127;

	// Active-low segment code for a dark digit
	localparam logic [7:0] SEG_BLANK = 8'hFF;

	typedef struct packed {
		logic [1:0] op;
		logic       tick;
		logic       road1_request;
		logic       road2_request;
		logic       exit_request;
	} in_item_t;

	typedef struct packed {
		logic       red_one;
		logic       yellow_one;
		logic       green_one;
		logic       red_two;
		logic       yellow_two;
		logic       green_two;
		logic [7:0] road1_tens_seg;
		logic [7:0] road1_ones_seg;
		logic [7:0] road2_tens_seg;
		logic [7:0] road2_ones_seg;
	} out_item_t;

	// Lamp state of both roads
	typedef struct packed {
		logic red_one;
		logic yellow_one;
		logic green_one;
		logic red_two;
		logic yellow_two;
		logic green_two;
	} lamps_t;

	// Decimal digit to active-low segment code
	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0:    code = 8'hC0;
			4'd1:    code = 8'hF9;
			4'd2:    code = 8'hA4;
			4'd3:    code = 8'hB0;
			4'd4:    code = 8'h99;
			4'd5:    code = 8'h92;
			4'd6:    code = 8'h82;
			4'd7:    code = 8'hF8;
			4'd8:    code = 8'h80;
			4'd9:    code = 8'h90;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/ttlc_digits.sv =====
// Split a countdown value into tens and ones and encode both as segment codes.
module ttlc_digits (
	input  logic [ttlc_pkg::COUNT_W-1:0] value,
	output logic [7:0]                   tens_seg,
	output logic [7:0]                   ones_seg
);

	logic [14:0] prod;
	logic [2:0]  tens;
	logic [6:0]  tens_x10;
	logic [6:0]  ones;

	// Divide by ten through the reciprocal 205/2048, exact for values below 80
	assign prod     = {8'd0, value} * 15'd205;
	assign tens     = prod[13:11];
	assign tens_x10 = {1'b0, tens, 3'd0} + {3'd0, tens, 1'b0};
	assign ones     = value - tens_x10;

	assign tens_seg = ttlc_pkg::seg_code({1'b0, tens});
	assign ones_seg = ttlc_pkg::seg_code(ones[3:0]);

endmodule

// ===== rtl/two_road_traffic_light_controller.sv =====
// Top level of the two-road traffic light controller: handshake, state and lamp logic.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | to block  | in_valid/in_stall  | in_item   (ttlc_pkg::in_item_t)
//  out     | from blk  | out_valid/out_stall| out_item  (ttlc_pkg::out_item_t)
//  cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; each item is held in the input
// register and then lands in the result register.
// Phase, elapsed count and lamps update when an item moves to the result register.
// Reset sets the green times to 20, the yellow time to 3, phase 0, lamps off.
// A stalled result holds; the input register still takes one item while it is
// empty, then the input stalls until the result drains. cfg_ready is always high.
module two_road_traffic_light_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  ttlc_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output ttlc_pkg::out_item_t               out_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ttlc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ttlc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [1:0] {
		PH_ROAD1_GREEN  = 2'd0,
		PH_ROAD1_YELLOW = 2'd1,
		PH_ROAD2_GREEN  = 2'd2,
		PH_ROAD2_YELLOW = 2'd3
	} phase_t;

	localparam int unsigned CW = ttlc_pkg::COUNT_W;

	// Configuration registers
	logic [ttlc_pkg::GREEN_W-1:0]  road1_green_q;
	logic [ttlc_pkg::GREEN_W-1:0]  road2_green_q;
	logic [ttlc_pkg::YELLOW_W-1:0] yellow_q;

	// Controller state
	phase_t           phase_q;
	logic [CW-1:0]    elapsed_q;
	ttlc_pkg::lamps_t lamps_q;

	// Pipeline registers
	logic                valid_s1;
	ttlc_pkg::in_item_t  item_s1;
	logic                out_valid_q;
	ttlc_pkg::out_item_t out_item_q;

	logic s2_free;
	logic s1_adv;

	// Next-state logic
	logic [CW-1:0]    count_t;
	logic [CW-1:0]    green1_ext;
	logic [CW-1:0]    green2_ext;
	logic [CW-1:0]    yellow_ext;
	logic [CW-1:0]    remain1;
	logic [CW-1:0]    remain2;
	logic [CW-1:0]    remain_y;
	logic [CW-1:0]    cd1;
	logic [CW-1:0]    cd2;
	logic             blank;
	phase_t           phase_d;
	logic [CW-1:0]    elapsed_d;
	ttlc_pkg::lamps_t lamps_d;
	logic [7:0]       r1_tens;
	logic [7:0]       r1_ones;
	logic [7:0]       r2_tens;
	logic [7:0]       r2_ones;
	ttlc_pkg::out_item_t result;

	// Handshake
	assign s2_free   = !out_valid_q || !out_stall;
	assign s1_adv    = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Apply the tick, then work out the remaining times
	assign count_t    = (item_s1.tick && elapsed_q != ttlc_pkg::COUNT_MAX) ?
	                    elapsed_q + 7'd1 : elapsed_q;
	assign green1_ext = {1'b0, road1_green_q};
	assign green2_ext = {1'b0, road2_green_q};
	assign yellow_ext = {3'd0, yellow_q};
	assign remain1    = (green1_ext > count_t) ? green1_ext - count_t : '0;
	assign remain2    = (green2_ext > count_t) ? green2_ext - count_t : '0;
	assign remain_y   = (yellow_ext > count_t) ? yellow_ext - count_t : '0;

	// Mode logic for one pass
	always_comb begin
		phase_d   = phase_q;
		elapsed_d = count_t;
		lamps_d   = lamps_q;
		cd1       = '0;
		cd2       = '0;
		blank     = 1'b1;
		case (item_s1.op)
			ttlc_pkg::OP_AUTO: begin
				blank = 1'b0;
				case (phase_q)
					PH_ROAD1_GREEN: begin
						lamps_d = '{red_one: 1'b0, yellow_one: 1'b0, green_one: 1'b1,
						            red_two: 1'b1, yellow_two: 1'b0, green_two: 1'b0};
						cd1 = remain1;
						cd2 = remain1 + yellow_ext + 7'd1;
						if (count_t > green1_ext) begin
							elapsed_d = '0;
							phase_d   = PH_ROAD1_YELLOW;
						end
					end
					PH_ROAD1_YELLOW: begin
						lamps_d.green_one  = 1'b0;
						lamps_d.yellow_two = 1'b0;
						lamps_d.yellow_one = 1'b1;
						cd1 = remain_y;
						cd2 = remain_y;
						if (count_t > yellow_ext) begin
							elapsed_d = '0;
							phase_d   = PH_ROAD2_GREEN;
						end
					end
					PH_ROAD2_GREEN: begin
						lamps_d = '{red_one: 1'b1, yellow_one: 1'b0, green_one: 1'b0,
						            red_two: 1'b0, yellow_two: 1'b0, green_two: 1'b1};
						cd2 = remain2;
						cd1 = remain2 + yellow_ext + 7'd1;
						if (count_t > green2_ext) begin
							elapsed_d = '0;
							phase_d   = PH_ROAD2_YELLOW;
						end
					end
					default: begin
						lamps_d.green_two  = 1'b0;
						lamps_d.yellow_one = 1'b0;
						lamps_d.yellow_two = 1'b1;
						cd2 = remain_y;
						cd1 = remain_y;
						if (count_t > yellow_ext) begin
							elapsed_d = '0;
							phase_d   = PH_ROAD1_GREEN;
						end
					end
				endcase
				if (item_s1.exit_request) begin
					phase_d = PH_ROAD1_GREEN;
				end
			end
			ttlc_pkg::OP_MANUAL: begin
				if (item_s1.road1_request) begin
					lamps_d = '{red_one: 1'b0, yellow_one: 1'b0, green_one: 1'b1,
					            red_two: 1'b1, yellow_two: 1'b0, green_two: 1'b0};
				end else if (item_s1.road2_request) begin
					lamps_d = '{red_one: 1'b1, yellow_one: 1'b0, green_one: 1'b0,
					            red_two: 1'b0, yellow_two: 1'b0, green_two: 1'b1};
				end
			end
			ttlc_pkg::OP_MIDNIGHT: begin
				lamps_d.red_one   = 1'b0;
				lamps_d.green_one = 1'b0;
				lamps_d.red_two   = 1'b0;
				lamps_d.green_two = 1'b0;
				if (count_t != '0) begin
					lamps_d.yellow_one = !lamps_q.yellow_one;
					lamps_d.yellow_two = !lamps_q.yellow_two;
					elapsed_d          = '0;
				end
			end
			default: begin
				// unused mode: hold lamps and phase
			end
		endcase
		// Exit clears the counter in every mode
		if (item_s1.exit_request) begin
			elapsed_d = '0;
		end
	end

	ttlc_digits u_road1_digits (
		.value    (cd1),
		.tens_seg (r1_tens),
		.ones_seg (r1_ones)
	);

	ttlc_digits u_road2_digits (
		.value    (cd2),
		.tens_seg (r2_tens),
		.ones_seg (r2_ones)
	);

	// Assemble the result item
	always_comb begin
		result.red_one        = lamps_d.red_one;
		result.yellow_one     = lamps_d.yellow_one;
		result.green_one      = lamps_d.green_one;
		result.red_two        = lamps_d.red_two;
		result.yellow_two     = lamps_d.yellow_two;
		result.green_two      = lamps_d.green_two;
		result.road1_tens_seg = blank ? ttlc_pkg::SEG_BLANK : r1_tens;
		result.road1_ones_seg = blank ? ttlc_pkg::SEG_BLANK : r1_ones;
		result.road2_tens_seg = blank ? ttlc_pkg::SEG_BLANK : r2_tens;
		result.road2_ones_seg = blank ? ttlc_pkg::SEG_BLANK : r2_ones;
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			road1_green_q <= ttlc_pkg::GREEN_RESET;
			road2_green_q <= ttlc_pkg::GREEN_RESET;
			yellow_q      <= ttlc_pkg::YELLOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ttlc_pkg::CFG_ROAD1_GREEN: road1_green_q <= cfg_data;
				ttlc_pkg::CFG_ROAD2_GREEN: road2_green_q <= cfg_data;
				ttlc_pkg::CFG_YELLOW:      yellow_q      <= cfg_data[ttlc_pkg::YELLOW_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: load when the slot is free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s2_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// Result register and controller state: advance with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= PH_ROAD1_GREEN;
			elapsed_q   <= '0;
			lamps_q     <= '0;
		end else begin
			if (s2_free) begin
				out_valid_q <= valid_s1;
			end
			if (s1_adv) begin
				phase_q   <= phase_d;
				elapsed_q <= elapsed_d;
				lamps_q   <= lamps_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_item_q <= result;
		end
	end

endmodule

// ===== rtl/ttlc_checker.sv =====
// Port-level checks on the traffic light controller, bound to its top level.
module ttlc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input ttlc_pkg::out_item_t out_item
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// Blank all four digits together
	a_blank_all: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.road1_tens_seg == ttlc_pkg::SEG_BLANK |->
		out_item.road1_ones_seg == ttlc_pkg::SEG_BLANK &&
		out_item.road2_tens_seg == ttlc_pkg::SEG_BLANK &&
		out_item.road2_ones_seg == ttlc_pkg::SEG_BLANK)
		else $error("digits partly blanked");

	// Never give both roads green
	a_one_green: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.green_one && out_item.green_two))
		else $error("both roads green");

	// Green excludes the same road's yellow
	a_green_yellow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.green_one && out_item.yellow_one) &&
		!(out_item.green_two && out_item.yellow_two))
		else $error("green and yellow lit on one road");

endmodule

bind two_road_traffic_light_controller ttlc_checker u_ttlc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ===== verif/two_road_traffic_light_controller_tb.sv =====
// Self-checking testbench for the two-road traffic light controller.
`timescale 1ns / 1ps

module two_road_traffic_light_controller_tb;

	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          DRAIN_CYCLES = 4;
	localparam int          HOLD_AT      = 400;
	localparam int          HOLD_CYCLES  = 80;
	localparam int          PHASE_ITEMS  = 325;
	localparam logic [1:0]  OP_SPARE     = 2'd3;
	localparam logic [1:0]  CFG_SPARE    = 2'd3;

	// Auto-mode phases
	typedef enum logic [1:0] {
		ROAD1_GO    = 2'd0,
		ROAD1_CLEAR = 2'd1,
		ROAD2_GO    = 2'd2,
		ROAD2_CLEAR = 2'd3
	} auto_phase_t;

	// Shapes of random stimulus
	typedef enum int {
		BURST_AUTO,
		BURST_MANUAL,
		BURST_MIDNIGHT,
		BURST_COUNT_UP,
		BURST_NOISE
	} burst_t;

	typedef struct packed {
		ttlc_pkg::in_item_t  item;
		logic                typed;
		ttlc_pkg::out_item_t want;
	} stim_row_t;

	localparam ttlc_pkg::out_item_t UNTYPED = '0;

	// Active-low digit codes, 0 through 9
	localparam logic [7:0] DIGIT_SEG [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	// Directed rows, run right after reset with the reset register values
	localparam int DIRECTED_ROWS = 18;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{ttlc_pkg::OP_AUTO,     1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'hA4, 8'hC0, 8'hA4, 8'h99}},
		'{'{ttlc_pkg::OP_MANUAL,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
				ttlc_pkg::SEG_BLANK, ttlc_pkg::SEG_BLANK,
				ttlc_pkg::SEG_BLANK, ttlc_pkg::SEG_BLANK}},
		'{'{ttlc_pkg::OP_MANUAL,   1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_MANUAL,   1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_MIDNIGHT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_MIDNIGHT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_MIDNIGHT, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_MIDNIGHT, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_MIDNIGHT, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{OP_SPARE,              1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{OP_SPARE,              1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, UNTYPED},
		'{'{OP_SPARE,              1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_AUTO,     1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_AUTO,     1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_AUTO,     1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_MANUAL,   1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, UNTYPED},
		'{'{OP_SPARE,              1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, UNTYPED},
		'{'{ttlc_pkg::OP_AUTO,     1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, UNTYPED}
	};

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	ttlc_pkg::in_item_t                 in_item;
	logic                               out_valid;
	logic                               out_stall;
	ttlc_pkg::out_item_t                out_item;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [ttlc_pkg::CFG_INDEX_W-1:0]   cfg_index;
	logic [ttlc_pkg::CFG_DATA_W-1:0]    cfg_data;

	// Predictor state and register copies
	auto_phase_t                        phase_now;
	logic [ttlc_pkg::COUNT_W-1:0]       ticks_now;
	ttlc_pkg::lamps_t                   lamps_now;
	logic [ttlc_pkg::GREEN_W-1:0]       road1_green;
	logic [ttlc_pkg::GREEN_W-1:0]       road2_green;
	logic [ttlc_pkg::YELLOW_W-1:0]      yellow_len;

	ttlc_pkg::out_item_t                light_queue [$];
	ttlc_pkg::out_item_t                oldest_light;
	int                                 mismatches;
	int                                 cycle_count;

	two_road_traffic_light_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Time left in a phase, floored at zero
	function automatic logic [ttlc_pkg::COUNT_W-1:0] time_left(
			logic [ttlc_pkg::GREEN_W-1:0] span, logic [ttlc_pkg::COUNT_W-1:0] count);
		return ({1'b0, span} > count) ? ({1'b0, span} - count) : '0;
	endfunction

	// Opposite road follows road1 during a green phase
	function automatic ttlc_pkg::lamps_t mirror_road2(ttlc_pkg::lamps_t l);
		l.red_two   = l.green_one;
		l.green_two = l.red_one;
		return l;
	endfunction

	function automatic ttlc_pkg::lamps_t road1_green_lamps(ttlc_pkg::lamps_t l);
		l.red_one    = 1'b0;
		l.yellow_one = 1'b0;
		l.yellow_two = 1'b0;
		l.green_one  = 1'b1;
		return mirror_road2(l);
	endfunction

	function automatic ttlc_pkg::lamps_t road2_green_lamps(ttlc_pkg::lamps_t l);
		l.green_one  = 1'b0;
		l.yellow_one = 1'b0;
		l.yellow_two = 1'b0;
		l.red_one    = 1'b1;
		return mirror_road2(l);
	endfunction

	// Advance the predicted controller by one pass and return its lights
	function automatic ttlc_pkg::out_item_t step_controller(ttlc_pkg::in_item_t it);
		ttlc_pkg::out_item_t          lights;
		logic [ttlc_pkg::COUNT_W-1:0] cd1;
		logic [ttlc_pkg::COUNT_W-1:0] cd2;
		logic                         blank;
		cd1   = '0;
		cd2   = '0;
		blank = 1'b1;
		if (it.tick && ticks_now != ttlc_pkg::COUNT_MAX)
			ticks_now = ticks_now + 1'b1;
		case (it.op)
			ttlc_pkg::OP_AUTO: begin
				blank = 1'b0;
				case (phase_now)
					ROAD1_GO: begin
						lamps_now = road1_green_lamps(lamps_now);
						cd1 = time_left(road1_green, ticks_now);
						cd2 = cd1 + yellow_len + 1'b1;
						if (ticks_now > road1_green) begin
							ticks_now = '0;
							phase_now = ROAD1_CLEAR;
						end
					end
					ROAD1_CLEAR: begin
						lamps_now.green_one  = 1'b0;
						lamps_now.yellow_two = 1'b0;
						lamps_now.yellow_one = 1'b1;
						cd1 = time_left({2'b00, yellow_len}, ticks_now);
						cd2 = cd1;
						if (ticks_now > yellow_len) begin
							ticks_now = '0;
							phase_now = ROAD2_GO;
						end
					end
					ROAD2_GO: begin
						lamps_now = road2_green_lamps(lamps_now);
						cd2 = time_left(road2_green, ticks_now);
						cd1 = cd2 + yellow_len + 1'b1;
						if (ticks_now > road2_green) begin
							ticks_now = '0;
							phase_now = ROAD2_CLEAR;
						end
					end
					default: begin
						lamps_now.green_two  = 1'b0;
						lamps_now.yellow_one = 1'b0;
						lamps_now.yellow_two = 1'b1;
						cd2 = time_left({2'b00, yellow_len}, ticks_now);
						cd1 = cd2;
						if (ticks_now > yellow_len) begin
							ticks_now = '0;
							phase_now = ROAD1_GO;
						end
					end
				endcase
				// Exit keeps this pass's lights, then restarts the cycle
				if (it.exit_request) begin
					ticks_now = '0;
					phase_now = ROAD1_GO;
				end
			end
			ttlc_pkg::OP_MANUAL: begin
				if (it.road1_request)
					lamps_now = road1_green_lamps(lamps_now);
				else if (it.road2_request)
					lamps_now = road2_green_lamps(lamps_now);
				if (it.exit_request)
					ticks_now = '0;
			end
			ttlc_pkg::OP_MIDNIGHT: begin
				lamps_now.red_one   = 1'b0;
				lamps_now.green_one = 1'b0;
				lamps_now.red_two   = 1'b0;
				lamps_now.green_two = 1'b0;
				// Blink both yellows once per elapsed tick
				if (ticks_now >= 1) begin
					lamps_now.yellow_one = ~lamps_now.yellow_one;
					lamps_now.yellow_two = ~lamps_now.yellow_two;
					ticks_now = '0;
				end
				if (it.exit_request)
					ticks_now = '0;
			end
			default: begin
				if (it.exit_request)
					ticks_now = '0;
			end
		endcase
		lights.red_one    = lamps_now.red_one;
		lights.yellow_one = lamps_now.yellow_one;
		lights.green_one  = lamps_now.green_one;
		lights.red_two    = lamps_now.red_two;
		lights.yellow_two = lamps_now.yellow_two;
		lights.green_two  = lamps_now.green_two;
		if (blank) begin
			lights.road1_tens_seg = ttlc_pkg::SEG_BLANK;
			lights.road1_ones_seg = ttlc_pkg::SEG_BLANK;
			lights.road2_tens_seg = ttlc_pkg::SEG_BLANK;
			lights.road2_ones_seg = ttlc_pkg::SEG_BLANK;
		end else begin
			lights.road1_tens_seg = DIGIT_SEG[(int'(cd1) / 10) % 10];
			lights.road1_ones_seg = DIGIT_SEG[int'(cd1) % 10];
			lights.road2_tens_seg = DIGIT_SEG[(int'(cd2) / 10) % 10];
			lights.road2_ones_seg = DIGIT_SEG[int'(cd2) % 10];
		end
		return lights;
	endfunction

	// Wait per item, with steady stretches of no idling
	function automatic int draw_wait(int n);
		if ((n / 80) % 4 == 3)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	function automatic ttlc_pkg::in_item_t pack_in(logic [1:0] op, logic tick, logic r1,
			logic r2, logic ex);
		ttlc_pkg::in_item_t it;
		it.op            = op;
		it.tick          = tick;
		it.road1_request = r1;
		it.road2_request = r2;
		it.exit_request  = ex;
		return it;
	endfunction

	// Offer one item, predict its lights once it is taken
	int sent_count;
	task automatic send_item(ttlc_pkg::in_item_t it, logic typed, ttlc_pkg::out_item_t want);
		int                  gap;
		ttlc_pkg::out_item_t lights;
		gap = draw_wait(sent_count);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		lights = step_controller(it);
		light_queue.push_back(typed ? want : lights);
		sent_count++;
	endtask

	// Write one register; the caller lowers cfg_valid after the batch
	task automatic write_reg(logic [ttlc_pkg::CFG_INDEX_W-1:0] idx,
			logic [ttlc_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			ttlc_pkg::CFG_ROAD1_GREEN: road1_green = val;
			ttlc_pkg::CFG_ROAD2_GREEN: road2_green = val;
			ttlc_pkg::CFG_YELLOW:      yellow_len  = val[ttlc_pkg::YELLOW_W-1:0];
			default:                   ;
		endcase
	endtask

	task automatic program_timing(logic [ttlc_pkg::CFG_DATA_W-1:0] g1,
			logic [ttlc_pkg::CFG_DATA_W-1:0] g2, logic [ttlc_pkg::CFG_DATA_W-1:0] y,
			logic touch_spare);
		write_reg(ttlc_pkg::CFG_ROAD1_GREEN, g1);
		write_reg(ttlc_pkg::CFG_ROAD2_GREEN, g2);
		write_reg(ttlc_pkg::CFG_YELLOW, y);
		if (touch_spare)
			write_reg(CFG_SPARE, 6'h2A);
		cfg_valid <= 1'b0;
	endtask

	// Hold until every expected result has come out, then let the pipe settle
	task automatic drain_block();
		in_valid <= 1'b0;
		while (light_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random items in bursts of well-formed mode runs, with noise mixed in
	task automatic run_random(int count);
		burst_t             shape;
		int                 left_in_burst;
		int                 pick;
		logic               first;
		ttlc_pkg::in_item_t it;
		left_in_burst = 0;
		first         = 1'b0;
		shape         = BURST_AUTO;
		for (int i = 0; i < count; i++) begin
			if (left_in_burst == 0) begin
				pick  = $urandom_range(0, 99);
				first = 1'b1;
				if (pick < 45) begin
					shape = BURST_AUTO;
					left_in_burst = $urandom_range(20, 120);
				end else if (pick < 65) begin
					shape = BURST_MANUAL;
					left_in_burst = $urandom_range(3, 20);
				end else if (pick < 80) begin
					shape = BURST_MIDNIGHT;
					left_in_burst = $urandom_range(3, 20);
				end else if (pick < 95) begin
					shape = BURST_NOISE;
					left_in_burst = $urandom_range(1, 8);
				end else begin
					shape = BURST_COUNT_UP;
					left_in_burst = $urandom_range(130, 140);
				end
			end
			case (shape)
				BURST_AUTO:
					it = pack_in(ttlc_pkg::OP_AUTO, $urandom_range(0, 3) != 0,
						$urandom_range(0, 1), $urandom_range(0, 1),
						first || $urandom_range(0, 40) == 0);
				BURST_MANUAL:
					it = pack_in(ttlc_pkg::OP_MANUAL, $urandom_range(0, 1),
						$urandom_range(0, 3) == 0, $urandom_range(0, 1),
						first || $urandom_range(0, 10) == 0);
				BURST_MIDNIGHT:
					it = pack_in(ttlc_pkg::OP_MIDNIGHT, $urandom_range(0, 2) == 0,
						$urandom_range(0, 1), $urandom_range(0, 1),
						first || $urandom_range(0, 10) == 0);
				BURST_COUNT_UP:
					// Tick without clearing so the counter reaches saturation
					it = pack_in($urandom_range(0, 1) ? ttlc_pkg::OP_MANUAL : OP_SPARE, 1'b1,
						$urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
				default:
					it = ttlc_pkg::in_item_t'($urandom_range(0, 63));
			endcase
			send_item(it, 1'b0, UNTYPED);
			first = 1'b0;
			left_in_burst--;
		end
	endtask

	// Compare one field of a result
	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Check each taken result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (light_queue.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, out_item);
				mismatches++;
			end else begin
				oldest_light = light_queue.pop_front();
				check_field("red_one", oldest_light.red_one, out_item.red_one);
				check_field("yellow_one", oldest_light.yellow_one, out_item.yellow_one);
				check_field("green_one", oldest_light.green_one, out_item.green_one);
				check_field("red_two", oldest_light.red_two, out_item.red_two);
				check_field("yellow_two", oldest_light.yellow_two, out_item.yellow_two);
				check_field("green_two", oldest_light.green_two, out_item.green_two);
				check_field("road1_tens_seg", oldest_light.road1_tens_seg,
					out_item.road1_tens_seg);
				check_field("road1_ones_seg", oldest_light.road1_ones_seg,
					out_item.road1_ones_seg);
				check_field("road2_tens_seg", oldest_light.road2_tens_seg,
					out_item.road2_tens_seg);
				check_field("road2_ones_seg", oldest_light.road2_ones_seg,
					out_item.road2_ones_seg);
			end
		end
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("two_road_traffic_light_controller: mismatch");
			$finish;
		end
	end

	// Result side: random stalls per item, one long hold-off to back up the block
	initial begin : result_side
		int taken;
		int hold;
		taken     = 0;
		out_stall = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			hold = (taken == HOLD_AT) ? HOLD_CYCLES : draw_wait(taken);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_item     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		mismatches  = 0;
		cycle_count = 0;
		sent_count  = 0;
		phase_now   = ROAD1_GO;
		ticks_now   = '0;
		lamps_now   = '0;
		road1_green = ttlc_pkg::GREEN_RESET;
		road2_green = ttlc_pkg::GREEN_RESET;
		yellow_len  = ttlc_pkg::YELLOW_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows on the reset timing
		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
		drain_block();

		// Random phases across several timing settings
		program_timing(6'd1, 6'd1, 6'd1, 1'b1);
		run_random(PHASE_ITEMS);
		drain_block();
		program_timing(6'd60, 6'd60, 6'd9, 1'b0);
		run_random(PHASE_ITEMS);
		drain_block();
		program_timing(6'd0, 6'd0, 6'd0, 1'b0);
		run_random(PHASE_ITEMS);
		drain_block();
		program_timing(6'd63, 6'd63, 6'd63, 1'b0);
		run_random(PHASE_ITEMS);
		drain_block();
		program_timing($urandom_range(1, 60), $urandom_range(1, 60), $urandom_range(1, 9),
			1'b0);
		run_random(PHASE_ITEMS);
		drain_block();
		program_timing($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
			1'b1);
		run_random(PHASE_ITEMS);
		drain_block();

		if (mismatches == 0)
			$display("two_road_traffic_light_controller: match");
		else
			$display("two_road_traffic_light_controller: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ttlc_pkg.sv
rtl/ttlc_digits.sv
rtl/two_road_traffic_light_controller.sv
rtl/ttlc_checker.sv
verif/two_road_traffic_light_controller_tb.sv
